// ----- rtl/rsa_pkg.sv -----
package rsa_pkg;

  localparam int NUM_REGS  = 16;
  localparam int MAX_BYTES = 8;

  localparam int ROW_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int COL_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W  = $clog2(MAX_BYTES + 1);
  localparam int TGT_W  = 7;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 2;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [CIDX_W-1:0] {
    CFG_HEADER  = 2'd0,
    CFG_DEV_ID  = 2'd1,
    CFG_REG_CNT = 2'd2,
    CFG_TIMEOUT = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_WORKING  = 3'd0,
    ST_OK       = 3'd1,
    ST_ADDR_ERR = 3'd2,
    ST_CSUM_ERR = 3'd3,
    ST_TIMEOUT  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_ID     = 3'd1,
    PH_ADDR   = 3'd2,
    PH_DATA   = 3'd3,
    PH_SUM    = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_COMMIT,
    SQ_ACK,
    SQ_RDREQ,
    SQ_RDOUT,
    SQ_RDSUM
  } seq_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [7:0]  device_id;
    logic [4:0]  reg_count;
    logic [15:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             set_valid;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [7:0]       wdata;
  } st_req_t;

endpackage

// ----- rtl/rsa_regstore.sv -----
module rsa_regstore (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rsa_pkg::st_req_t req_i,
  output logic [7:0]       rdata_o
);
  import rsa_pkg::*;

  localparam int DEPTH = NUM_REGS * MAX_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]          mem [DEPTH];
  logic [NUM_REGS-1:0] row_vld_q;
  logic [7:0]          raw_q;
  logic                rd_vld_q;
  logic [AW-1:0]       addr;

  assign addr = AW'(AW'(req_i.row) * AW'(MAX_BYTES) + AW'(req_i.col));

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      raw_q <= mem[addr];
    end
  end

  // rows never committed since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.wr_en && req_i.set_valid) begin
        row_vld_q[req_i.row] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= row_vld_q[req_i.row];
      end
    end
  end

  assign rdata_o = rd_vld_q ? raw_q : 8'h00;

endmodule

// ----- rtl/rsa_parser.sv -----
module rsa_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rsa_pkg::in_item_t  in_data_i,
  input  rsa_pkg::cfg_t      cfg_i,
  input  logic               out_free_i,
  output logic               push_o,
  output rsa_pkg::out_item_t res_o,
  output rsa_pkg::st_req_t   st_req_o,
  input  logic [7:0]         st_rdata_i
);
  import rsa_pkg::*;

  seq_e             seq_q, seq_d;
  phase_e           phase_q, phase_d;
  in_item_t         in_q;
  logic [7:0]       sum_q, sum_d;
  logic [TGT_W-1:0] target_q, target_d;
  logic             is_write_q, is_write_d;
  logic [CNT_W-1:0] bc_q, bc_d;
  logic [15:0]      tick_q, tick_d;

  logic [7:0]       wbuf_mem [MAX_BYTES];
  logic [7:0]       wbuf_rdata_q;
  logic             wbuf_we, wbuf_re;

  logic             accept, is_tick, timeout, addr_bad, sum_ok, data_last, good_sum;
  logic             sweep_done, rd_last;
  logic [7:0]       b;
  logic [15:0]      tick_inc;
  logic [CNT_W-1:0] bc_prev;

  assign accept     = in_valid_i && (seq_q == SQ_IDLE);
  assign in_stall_o = (seq_q != SQ_IDLE);

  assign b          = in_q.rx_byte;
  assign is_tick    = (in_q.cmd == CMD_TICK);
  assign tick_inc   = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
  assign timeout    = (tick_inc > cfg_i.timeout_limit);
  assign addr_bad   = ({1'b0, b[TGT_W-1:0]} >= {3'b000, cfg_i.reg_count})
                   || ({1'b0, b[TGT_W-1:0]} >= 8'(NUM_REGS));
  assign sum_ok     = (b == sum_q);
  assign data_last  = (bc_q == CNT_W'(MAX_BYTES - 1));
  assign good_sum   = !is_tick && (phase_q == PH_SUM) && sum_ok;
  assign sweep_done = (bc_q == CNT_W'(MAX_BYTES));
  assign rd_last    = (bc_q == CNT_W'(MAX_BYTES - 1));
  assign bc_prev    = bc_q - CNT_W'(1);

  // sequencer
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SQ_IDLE:   if (accept) seq_d = SQ_EXEC;
      SQ_EXEC: begin
        if (out_free_i) begin
          if (good_sum) begin
            seq_d = is_write_q ? SQ_COMMIT : SQ_RDREQ;
          end else begin
            seq_d = SQ_IDLE;
          end
        end
      end
      SQ_COMMIT: if (sweep_done) seq_d = SQ_ACK;
      SQ_ACK:    if (out_free_i) seq_d = SQ_IDLE;
      SQ_RDREQ:  seq_d = SQ_RDOUT;
      SQ_RDOUT: begin
        if (out_free_i) begin
          seq_d = rd_last ? SQ_RDSUM : SQ_RDREQ;
        end
      end
      SQ_RDSUM:  if (out_free_i) seq_d = SQ_IDLE;
      default:   seq_d = SQ_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_d    = phase_q;
    sum_d      = sum_q;
    target_d   = target_q;
    is_write_d = is_write_q;
    bc_d       = bc_q;
    tick_d     = tick_q;
    push_o     = 1'b0;
    res_o      = '{status: ST_WORKING, tx_valid: 1'b0, tx_byte: 8'h00, last: 1'b1};
    wbuf_we    = 1'b0;
    wbuf_re    = 1'b0;
    st_req_o   = '{rd_en: 1'b0, wr_en: 1'b0, set_valid: 1'b0,
                   row: target_q[ROW_W-1:0], col: bc_q[COL_W-1:0], wdata: wbuf_rdata_q};

    unique case (seq_q)
      SQ_EXEC: begin
        if (out_free_i) begin
          push_o = 1'b1;
          if (is_tick) begin
            if (phase_q != PH_HEADER) begin
              tick_d = tick_inc;
              if (timeout) begin
                phase_d      = PH_HEADER;
                tick_d       = 16'd0;
                res_o.status = ST_TIMEOUT;
              end
            end
          end else begin
            tick_d = 16'd0;
            unique case (phase_q)
              PH_HEADER: begin
                if (b == cfg_i.header_byte) begin
                  phase_d = PH_ID;
                  sum_d   = cfg_i.header_byte;
                  bc_d    = '0;
                end
              end
              PH_ID: begin
                if (b == cfg_i.device_id) begin
                  phase_d = PH_ADDR;
                  sum_d   = sum_q + b;
                end else begin
                  phase_d = PH_HEADER;
                end
              end
              PH_ADDR: begin
                target_d   = b[TGT_W-1:0];
                is_write_d = b[7];
                sum_d      = sum_q + b;
                if (addr_bad) begin
                  phase_d      = PH_HEADER;
                  res_o.status = ST_ADDR_ERR;
                end else begin
                  phase_d = b[7] ? PH_DATA : PH_SUM;
                end
              end
              PH_DATA: begin
                wbuf_we = 1'b1;
                bc_d    = bc_q + CNT_W'(1);
                sum_d   = sum_q + b;
                if (data_last) phase_d = PH_SUM;
              end
              PH_SUM: begin
                phase_d = PH_HEADER;
                if (!sum_ok) begin
                  res_o.status = ST_CSUM_ERR;
                end else if (is_write_q) begin
                  // ack goes out after the commit sweep
                  push_o = 1'b0;
                  bc_d   = '0;
                end else begin
                  res_o = '{status: ST_OK, tx_valid: 1'b1,
                            tx_byte: cfg_i.header_byte, last: 1'b0};
                  sum_d = cfg_i.header_byte;
                  bc_d  = '0;
                end
              end
              default: phase_d = PH_HEADER;
            endcase
          end
        end
      end
      SQ_COMMIT: begin
        // buffer read is registered and feeds the store write in the next cycle
        wbuf_re = !sweep_done;
        if (!sweep_done) bc_d = bc_q + CNT_W'(1);
        if (bc_q != '0) begin
          st_req_o.wr_en     = 1'b1;
          st_req_o.col       = bc_prev[COL_W-1:0];
          st_req_o.set_valid = sweep_done;
        end
      end
      SQ_ACK: begin
        if (out_free_i) begin
          push_o = 1'b1;
          res_o  = '{status: ST_OK, tx_valid: 1'b1, tx_byte: cfg_i.header_byte, last: 1'b1};
        end
      end
      SQ_RDREQ: begin
        st_req_o.rd_en = 1'b1;
      end
      SQ_RDOUT: begin
        if (out_free_i) begin
          push_o = 1'b1;
          res_o  = '{status: ST_OK, tx_valid: 1'b1, tx_byte: st_rdata_i, last: 1'b0};
          sum_d  = sum_q + st_rdata_i;
          bc_d   = bc_q + CNT_W'(1);
        end
      end
      SQ_RDSUM: begin
        if (out_free_i) begin
          push_o = 1'b1;
          res_o  = '{status: ST_OK, tx_valid: 1'b1, tx_byte: sum_q, last: 1'b1};
        end
      end
      SQ_IDLE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wbuf_we) begin
      wbuf_mem[bc_q[COL_W-1:0]] <= b;
    end
    if (wbuf_re) begin
      wbuf_rdata_q <= wbuf_mem[bc_q[COL_W-1:0]];
    end
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q      <= SQ_IDLE;
      phase_q    <= PH_HEADER;
      sum_q      <= 8'h00;
      target_q   <= '0;
      is_write_q <= 1'b0;
      bc_q       <= '0;
      tick_q     <= 16'd0;
    end else begin
      seq_q      <= seq_d;
      phase_q    <= phase_d;
      sum_q      <= sum_d;
      target_q   <= target_d;
      is_write_q <= is_write_d;
      bc_q       <= bc_d;
      tick_q     <= tick_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> out_free_i)
    else $error("result pushed into an occupied output register");

  a_bc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= CNT_W'(MAX_BYTES))
    else $error("byte counter past register length");

  a_data_bc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (bc_q < CNT_W'(MAX_BYTES)))
    else $error("data phase with full write buffer");

  a_sweep_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_COMMIT || seq_q == SQ_RDOUT || seq_q == SQ_RDSUM)
      |-> (phase_q == PH_HEADER))
    else $error("response sweep while a packet is still being parsed");

  a_commit_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_COMMIT && st_req_o.set_valid) |=> (seq_q == SQ_ACK))
    else $error("commit finished without acknowledge");
`endif

endmodule

// ----- rtl/serial_register_access_slave_core.sv -----
// Flow: each input byte or tick is taken into the input register, and its result is
// written to the output register; no new item is taken until the last is done. A good
// write then runs the commit sweep and the acknowledge; a good read sends each register
// byte and then the checksum byte. Output stalls hold each result until it is taken.
// Reset: config registers take their defaults, the parse waits for a header and
// per-register valid bits make every register read as zero; no clearing pass.
module serial_register_access_slave_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  rsa_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output rsa_pkg::out_item_t        out_data_o,
  input  logic                      cfg_we_i,
  input  logic [rsa_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [rsa_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import rsa_pkg::*;

  cfg_t      cfg_q;
  out_item_t out_q, res;
  logic      out_valid_q;
  logic      out_free, push;
  st_req_t   st_req;
  logic [7:0] st_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte   <= 8'd170;
      cfg_q.device_id     <= 8'd1;
      cfg_q.reg_count     <= 5'd16;
      cfg_q.timeout_limit <= 16'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HEADER:  cfg_q.header_byte   <= cfg_wdata_i[7:0];
        CFG_DEV_ID:  cfg_q.device_id     <= cfg_wdata_i[7:0];
        CFG_REG_CNT: cfg_q.reg_count     <= cfg_wdata_i[4:0];
        CFG_TIMEOUT: cfg_q.timeout_limit <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  rsa_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .out_free_i (out_free),
    .push_o     (push),
    .res_o      (res),
    .st_req_o   (st_req),
    .st_rdata_i (st_rdata)
  );

  rsa_regstore u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (st_req),
    .rdata_o (st_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- test/serial_register_access_slave_core_test.sv -----
module serial_register_access_slave_core_test;
  import rsa_pkg::*;

  typedef enum {FLAW_NONE, FLAW_ID, FLAW_SUM, FLAW_TRUNC} flaw_e;
  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  class response_scoreboard;
    logic [7:0]  hdr;
    logic [7:0]  dev_id;
    logic [4:0]  reg_cnt;
    logic [15:0] tmo_limit;

    phase_e      phase;
    logic [7:0]  acc_sum;
    logic [6:0]  tgt_reg;
    logic        wr_op;
    logic [3:0]  nbytes;
    logic [15:0] stall_ticks;
    logic [7:0]  wbuf [MAX_BYTES];
    logic [7:0]  regs [NUM_REGS][MAX_BYTES];

    out_item_t   pending [$];
    int          mismatches;

    function new();
      hdr         = 8'd170;
      dev_id      = 8'd1;
      reg_cnt     = 5'd16;
      tmo_limit   = 16'd100;
      phase       = PH_HEADER;
      acc_sum     = '0;
      tgt_reg     = '0;
      wr_op       = 1'b0;
      nbytes      = '0;
      stall_ticks = '0;
      mismatches  = 0;
      foreach (wbuf[i]) wbuf[i] = '0;
      foreach (regs[r, c]) regs[r][c] = '0;
    endfunction

    function void set_cfg(cfg_idx_e idx, logic [15:0] v);
      case (idx)
        CFG_HEADER:  hdr       = v[7:0];
        CFG_DEV_ID:  dev_id    = v[7:0];
        CFG_REG_CNT: reg_cnt   = v[4:0];
        CFG_TIMEOUT: tmo_limit = v;
        default: ;
      endcase
    endfunction

    function void push(status_e st, logic vld, logic [7:0] b, logic lst);
      out_item_t e;
      e.status   = st;
      e.tx_valid = vld;
      e.tx_byte  = b;
      e.last     = lst;
      pending.push_back(e);
    endfunction

    // Advance the packet parser by one transaction and queue the responses it causes.
    function void parse_item(in_item_t it);
      logic [7:0] b;
      logic [7:0] s;
      logic [7:0] d;
      b = it.rx_byte;
      if (it.cmd == CMD_TICK) begin
        if (phase != PH_HEADER) begin
          if (stall_ticks != 16'hFFFF) stall_ticks = stall_ticks + 1'b1;
          if (stall_ticks > tmo_limit) begin
            phase       = PH_HEADER;
            stall_ticks = '0;
            push(ST_TIMEOUT, 1'b0, 8'h00, 1'b1);
            return;
          end
        end
        push(ST_WORKING, 1'b0, 8'h00, 1'b1);
        return;
      end
      stall_ticks = '0;
      case (phase)
        PH_HEADER: begin
          if (b == hdr) begin
            phase   = PH_ID;
            acc_sum = hdr;
            nbytes  = '0;
          end
        end
        PH_ID: begin
          if (b == dev_id) begin
            phase   = PH_ADDR;
            acc_sum = acc_sum + b;
          end else begin
            phase = PH_HEADER;
          end
        end
        PH_ADDR: begin
          tgt_reg = b[6:0];
          wr_op   = b[7];
          acc_sum = acc_sum + b;
          if (tgt_reg >= reg_cnt || tgt_reg >= NUM_REGS) begin
            phase = PH_HEADER;
            push(ST_ADDR_ERR, 1'b0, 8'h00, 1'b1);
            return;
          end
          phase = wr_op ? PH_DATA : PH_SUM;
        end
        PH_DATA: begin
          if (nbytes < MAX_BYTES) wbuf[nbytes] = b;
          nbytes = nbytes + 1'b1;
          if (nbytes >= MAX_BYTES) phase = PH_SUM;
          acc_sum = acc_sum + b;
        end
        PH_SUM: begin
          phase = PH_HEADER;
          if (b != acc_sum) begin
            push(ST_CSUM_ERR, 1'b0, 8'h00, 1'b1);
            return;
          end
          if (wr_op) begin
            for (int i = 0; i < MAX_BYTES; i++) regs[tgt_reg][i] = wbuf[i];
            push(ST_OK, 1'b1, hdr, 1'b1);
            return;
          end
          s = hdr;
          push(ST_OK, 1'b1, hdr, 1'b0);
          for (int i = 0; i < MAX_BYTES; i++) begin
            d = regs[tgt_reg][i];
            s = s + d;
            push(ST_OK, 1'b1, d, 1'b0);
          end
          push(ST_OK, 1'b1, s, 1'b1);
          return;
        end
        default: phase = PH_HEADER;
      endcase
      push(ST_WORKING, 1'b0, 8'h00, 1'b1);
    endfunction

    function void check_response(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
        mismatches++;
      end
      if (got.tx_valid !== e.tx_valid) begin
        $display("%0t: tx_valid expected %0d got %0d", $time, e.tx_valid, got.tx_valid);
        mismatches++;
      end
      if (got.tx_byte !== e.tx_byte) begin
        $display("%0t: tx_byte expected %h got %h", $time, e.tx_byte, got.tx_byte);
        mismatches++;
      end
      if (got.last !== e.last) begin
        $display("%0t: last expected %0d got %0d", $time, e.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [CIDX_W-1:0]   cfg_idx = '0;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  response_scoreboard  sb;
  int                  burst_left = 0;
  int                  items_sent = 0;
  int                  cyc = 0;
  stall_mode_e         stall_mode = STALL_NONE;

  serial_register_access_slave_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver backpressure, with the pattern chosen anew at random by the cycle counter.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 64 == 0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: out_stall <= (cyc % 4 == 1);
      default:        out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_response(out_data);
  end

  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.parse_item(it);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    in_item_t it;
    it.cmd     = CMD_BYTE;
    it.rx_byte = b;
    send_item(it);
  endtask

  task automatic send_tick();
    in_item_t it;
    it.cmd     = CMD_TICK;
    it.rx_byte = 8'($urandom);
    send_item(it);
  endtask

  // Occasional stray tick inside a packet; kept away from a zero limit so packets survive.
  task automatic maybe_tick();
    if (sb.tmo_limit != 0 && $urandom_range(0, 7) == 0) send_tick();
  endtask

  task automatic send_packet(logic [7:0] addr, flaw_e flaw, bit extreme);
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    sum = sb.hdr;
    send_byte(sb.hdr);
    maybe_tick();
    if (flaw == FLAW_ID) begin
      send_byte(sb.dev_id ^ 8'($urandom_range(1, 255)));
      return;
    end
    send_byte(sb.dev_id);
    sum = sum + sb.dev_id;
    maybe_tick();
    send_byte(addr);
    sum = sum + addr;
    if (addr[6:0] >= sb.reg_cnt || addr[6:0] >= NUM_REGS) return;
    if (addr[7]) begin
      for (int i = 0; i < MAX_BYTES; i++) begin
        b = extreme ? ((i % 2 == 0) ? 8'hFF : 8'h00) : 8'($urandom);
        send_byte(b);
        sum = sum + b;
        maybe_tick();
      end
    end
    if (flaw == FLAW_TRUNC) begin
      n = (sb.tmo_limit < 8) ? sb.tmo_limit + 1 + $urandom_range(0, 1) : $urandom_range(1, 4);
      repeat (n) send_tick();
      return;
    end
    if (flaw == FLAW_SUM) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_cfg(idx, v);
    @(posedge clk);
  endtask

  task automatic set_all_cfg(logic [7:0] h, logic [7:0] d, logic [4:0] rc, logic [15:0] t);
    write_cfg(CFG_HEADER, {8'h00, h});
    write_cfg(CFG_DEV_ID, {8'h00, d});
    write_cfg(CFG_REG_CNT, {11'h000, rc});
    write_cfg(CFG_TIMEOUT, t);
  endtask

  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_random(int budget);
    int         start;
    int         r;
    logic [7:0] addr;
    start = items_sent;
    while (items_sent - start < budget) begin
      if (sb.reg_cnt != 0 && $urandom_range(0, 7) != 0)
        addr[6:0] = 7'($urandom_range(0, (sb.reg_cnt > NUM_REGS ? NUM_REGS : sb.reg_cnt) - 1));
      else
        addr[6:0] = 7'($urandom_range(0, 127));
      addr[7] = 1'($urandom);
      r = $urandom_range(0, 99);
      if (r < 65)      send_packet(addr, FLAW_NONE, 1'b0);
      else if (r < 75) send_packet(addr, FLAW_SUM, 1'b0);
      else if (r < 83) send_packet(addr, FLAW_ID, 1'b0);
      else if (r < 91) send_packet(addr, FLAW_TRUNC, 1'b0);
      else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0) send_tick();
          else send_byte(8'($urandom));
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed checks at the reset configuration.
    send_byte(8'h00);                     // not a header, ignored
    send_tick();                          // tick while idle
    send_packet(8'h00, FLAW_NONE, 1'b0);  // read of a never-written register
    send_packet(8'h8F, FLAW_NONE, 1'b1);  // write top register, 0xFF/0x00 data
    send_packet(8'h0F, FLAW_NONE, 1'b0);  // read it back
    send_packet(8'h03, FLAW_ID, 1'b0);
    send_packet(8'h03, FLAW_SUM, 1'b0);
    send_packet(8'h90, FLAW_NONE, 1'b0);  // address equal to reg_count
    wait_idle();

    // Low extremes: no valid register, zero timeout.
    set_all_cfg(8'h00, 8'hFF, 5'd0, 16'd0);
    send_byte(8'h00);
    send_tick();                          // first tick mid-packet times out
    send_packet(8'h00, FLAW_NONE, 1'b0);
    run_random(15);
    wait_idle();

    // High extremes: timeout never fires.
    set_all_cfg(8'hFF, 8'h00, 5'd16, 16'hFFFF);
    run_random(20);
    wait_idle();

    set_all_cfg(8'($urandom), 8'($urandom), 5'd1, 16'd1);
    run_random(15);
    wait_idle();

    repeat (3) begin
      set_all_cfg(8'($urandom), 8'($urandom), 5'($urandom_range(0, 16)),
                  16'($urandom_range(0, 5)));
      run_random(13);
      wait_idle();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
